### rtl/core/bgm_pkg.sv
// ----------------------------------------------------------------------------
// Battery gauge monitor package
// Shared widths, register indexes, source codes, discharge curve and the
// packed request, response, configuration and divider types.
// ----------------------------------------------------------------------------
package bgm_pkg;

   // Field widths
   localparam int ADC_W      = 12;
   localparam int NUM_W      = 8;
   localparam int EMPTY_W    = 12;
   localparam int MV_W       = 16;
   localparam int PCT_W      = 7;
   localparam int SRC_W      = 2;

   // Register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER_NUM  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER_DEN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_MV     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_PCT      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL_PCT = 3'd4;

   // Register reset values
   localparam logic [NUM_W-1:0]   RST_DIVIDER_NUM  = 8'd2;
   localparam logic [NUM_W-1:0]   RST_DIVIDER_DEN  = 8'd1;
   localparam logic [EMPTY_W-1:0] RST_EMPTY_MV     = 12'd3300;
   localparam logic [PCT_W-1:0]   RST_LOW_PCT      = 7'd20;
   localparam logic [PCT_W-1:0]   RST_CRITICAL_PCT = 7'd5;

   // Power source codes
   localparam logic [SRC_W-1:0] SRC_BATTERY  = 2'd0;
   localparam logic [SRC_W-1:0] SRC_CHARGING = 2'd1;
   localparam logic [SRC_W-1:0] SRC_CHARGED  = 2'd2;
   localparam logic [SRC_W-1:0] SRC_UNKNOWN  = 2'd3;

   localparam logic [MV_W-1:0]  MV_MAX  = 16'hFFFF;
   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   // Fixed discharge curve, highest point first; the empty point is a register
   localparam int CURVE_N   = 9;
   localparam int CURVE_W   = 13;
   localparam int SEG_W     = 4;
   localparam int DPCT_W    = 5;

   localparam logic [CURVE_W-1:0] CURVE_MV [CURVE_N] = '{
      13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800,
      13'd3700, 13'd3600, 13'd3500, 13'd3400
   };
   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_N] = '{
      7'd100, 7'd90, 7'd80, 7'd65, 7'd45, 7'd25, 7'd12, 7'd5, 7'd2
   };

   // Shared divider
   localparam int DIV_DVD_W = 20;
   localparam int DIV_DVS_W = 12;
   localparam int DIV_CNT_W = 5;

   typedef struct packed {
      logic [ADC_W-1:0] adc_mv;
      logic             chrg_level;
      logic             stdby_level;
   } req_type;

   typedef struct packed {
      logic [MV_W-1:0]  vbat_mv;
      logic [PCT_W-1:0] soc_pct;
      logic [SRC_W-1:0] source;
      logic             low_flag;
      logic             critical_flag;
      logic             report;
   } rsp_type;

   typedef struct packed {
      logic [NUM_W-1:0]   divider_num;
      logic [NUM_W-1:0]   divider_den;
      logic [EMPTY_W-1:0] empty_mv;
      logic [PCT_W-1:0]   low_pct;
      logic [PCT_W-1:0]   critical_pct;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_DVD_W-1:0] dividend;
      logic [DIV_DVS_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic [DIV_DVD_W-1:0] quotient;
   } div_stat_type;

endpackage

### rtl/core/bgm_div.sv
// ----------------------------------------------------------------------------
// Battery gauge serial divider
// Restoring shift-subtract divider, one quotient bit per cycle. Used for
// both the divider-ratio scaling and the curve interpolation.
// ----------------------------------------------------------------------------
module bgm_div
   import bgm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_cmd_type  cmd,
   output div_stat_type stat
);

   logic [DIV_DVS_W-1:0] rem_ff, rem_in;
   logic [DIV_DVD_W-1:0] quo_ff, quo_in;
   logic [DIV_DVS_W-1:0] dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DVS_W:0]   trial;
   logic [DIV_DVS_W:0]   diff;
   logic                 fits;

   // Shift in the next dividend bit and try to subtract the divisor
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   // Load on start, then iterate until the count runs out
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (cmd.start) begin
         rem_in = '0;
         quo_in = cmd.dividend;
         dvs_in = cmd.divisor;
         cnt_in = DIV_CNT_W'(DIV_DVD_W);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
         quo_in = {quo_ff[DIV_DVD_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy     = (cnt_ff != '0);
   assign stat.quotient = quo_ff;

endmodule

### rtl/core/bgm_core.sv
// ----------------------------------------------------------------------------
// Battery gauge sequencer
// Steps one measurement round through scaling, curve lookup and
// interpolation on the shared divider, then derives source, flags and report.
// ----------------------------------------------------------------------------
module bgm_core
   import bgm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    res_valid,
   input  logic    res_take,
   output rsp_type res_data
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_MUL  = 9'b000000010,
      ST_DIV1 = 9'b000000100,
      ST_SAT  = 9'b000001000,
      ST_MAP  = 9'b000010000,
      ST_MUL2 = 9'b000100000,
      ST_DIV2 = 9'b001000000,
      ST_FLAG = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [MV_W-1:0]      mv_ff, mv_in;
   logic [DIV_DVS_W-1:0] offset_ff, offset_in;
   logic [DIV_DVS_W-1:0] span_ff, span_in;
   logic [DPCT_W-1:0]    dpct_ff, dpct_in;
   logic [PCT_W-1:0]     pct_lo_ff, pct_lo_in;
   rsp_type              res_ff, res_in;
   logic                 first_ff, first_in;
   logic [SRC_W-1:0]     last_src_ff, last_src_in;
   logic                 last_low_ff, last_low_in;
   logic                 last_crit_ff, last_crit_in;
   logic [PCT_W-1:0]     last_pct_ff, last_pct_in;

   div_cmd_type  div_cmd;
   div_stat_type div_stat;

   logic             seg_hit;
   logic [SEG_W-1:0] seg;
   logic [SEG_W-1:0] seg_hi;
   logic [PCT_W:0]   pct_sum;
   logic [PCT_W-1:0] pct;
   logic [PCT_W-1:0] pct_diff;
   logic [SRC_W-1:0] src;
   logic             low;
   logic             crit;
   logic             report;

   bgm_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   // Start the divider: ratio scaling first, interpolation second
   always_comb begin
      div_cmd.start = (state_ff == ST_MUL) || (state_ff == ST_MUL2);
      if (state_ff == ST_MUL) begin
         div_cmd.dividend = DIV_DVD_W'(req_ff.adc_mv) * DIV_DVD_W'(cfg.divider_num);
         div_cmd.divisor  = DIV_DVS_W'(cfg.divider_den);
      end else begin
         div_cmd.dividend = DIV_DVD_W'(offset_ff) * DIV_DVD_W'(dpct_ff);
         div_cmd.divisor  = span_ff;
      end
   end

   // Find the curve segment: the highest point at or below the voltage
   always_comb begin
      seg_hit = 1'b0;
      seg     = '0;
      for (int i = CURVE_N - 1; i >= 1; i--) begin
         if (mv_ff >= MV_W'(CURVE_MV[i])) begin
            seg_hit = 1'b1;
            seg     = SEG_W'(i);
         end
      end
      seg_hi = seg - SEG_W'(1);
   end

   // Interpolated percent, source decode, flags and report decision
   always_comb begin
      pct_sum = {1'b0, pct_lo_ff} + {1'b0, div_stat.quotient[PCT_W-1:0]};
      pct     = (pct_sum > {1'b0, PCT_MAX}) ? PCT_MAX : pct_sum[PCT_W-1:0];
      unique case ({req_ff.chrg_level, req_ff.stdby_level})
         2'b01:   src = SRC_CHARGING;
         2'b10:   src = SRC_CHARGED;
         2'b11:   src = SRC_BATTERY;
         default: src = SRC_UNKNOWN;
      endcase
      low      = (pct < cfg.low_pct) && (src == SRC_BATTERY);
      crit     = (pct < cfg.critical_pct) && (src == SRC_BATTERY);
      pct_diff = (pct >= last_pct_ff) ? (pct - last_pct_ff) : (last_pct_ff - pct);
      report   = first_ff || (src != last_src_ff) || (low != last_low_ff) ||
                 (crit != last_crit_ff) || (pct_diff >= PCT_W'(2));
   end

   // Sequencer and datapath registers
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      mv_in        = mv_ff;
      offset_in    = offset_ff;
      span_in      = span_ff;
      dpct_in      = dpct_ff;
      pct_lo_in    = pct_lo_ff;
      res_in       = res_ff;
      first_in     = first_ff;
      last_src_in  = last_src_ff;
      last_low_in  = last_low_ff;
      last_crit_in = last_crit_ff;
      last_pct_in  = last_pct_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            if (!div_stat.busy) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            // Saturate the scaled voltage; a zero denominator saturates too
            if ((cfg.divider_den == '0) || (div_stat.quotient[DIV_DVD_W-1:MV_W] != '0)) begin
               mv_in = MV_MAX;
            end else begin
               mv_in = div_stat.quotient[MV_W-1:0];
            end
            state_in = ST_MAP;
         end
         ST_MAP: begin
            // Flat ends run through the divider with a zero dividend
            priority if (mv_ff >= MV_W'(CURVE_MV[0])) begin
               offset_in = '0;
               span_in   = DIV_DVS_W'(1);
               dpct_in   = '0;
               pct_lo_in = PCT_MAX;
            end else if (seg_hit) begin
               offset_in = DIV_DVS_W'(mv_ff[CURVE_W-1:0] - CURVE_MV[seg]);
               span_in   = DIV_DVS_W'(CURVE_MV[seg_hi] - CURVE_MV[seg]);
               dpct_in   = DPCT_W'(CURVE_PCT[seg_hi] - CURVE_PCT[seg]);
               pct_lo_in = CURVE_PCT[seg];
            end else if ((CURVE_W'(cfg.empty_mv) < CURVE_MV[CURVE_N-1]) &&
                         (mv_ff >= MV_W'(cfg.empty_mv))) begin
               offset_in = DIV_DVS_W'(mv_ff[EMPTY_W-1:0] - cfg.empty_mv);
               span_in   = DIV_DVS_W'(CURVE_MV[CURVE_N-1] - CURVE_W'(cfg.empty_mv));
               dpct_in   = DPCT_W'(CURVE_PCT[CURVE_N-1]);
               pct_lo_in = '0;
            end else begin
               offset_in = '0;
               span_in   = DIV_DVS_W'(1);
               dpct_in   = '0;
               pct_lo_in = '0;
            end
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (!div_stat.busy) begin
               state_in = ST_FLAG;
            end
         end
         ST_FLAG: begin
            res_in.vbat_mv       = mv_ff;
            res_in.soc_pct       = pct;
            res_in.source        = src;
            res_in.low_flag      = low;
            res_in.critical_flag = crit;
            res_in.report        = report;
            // Remember the reported state only
            if (report) begin
               first_in     = 1'b0;
               last_src_in  = src;
               last_low_in  = low;
               last_crit_in = crit;
               last_pct_in  = pct;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         last_src_ff  <= SRC_BATTERY;
         last_low_ff  <= 1'b0;
         last_crit_ff <= 1'b0;
         last_pct_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         last_src_ff  <= last_src_in;
         last_low_ff  <= last_low_in;
         last_crit_ff <= last_crit_in;
         last_pct_ff  <= last_pct_in;
      end
      req_ff    <= req_in;
      mv_ff     <= mv_in;
      offset_ff <= offset_in;
      span_ff   <= span_in;
      dpct_ff   <= dpct_in;
      pct_lo_ff <= pct_lo_in;
      res_ff    <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = res_ff;

endmodule

### rtl/core/battery_gauge_monitor_top.sv
// ----------------------------------------------------------------------------
// Battery gauge monitor, top level
// Usage: one request is one measurement round (averaged ADC millivolts and
// the two charger status pins). The block returns one response per request:
// scaled battery millivolts, state of charge percent from the LiPo curve,
// power source, low and critical flags, and a report flag.
// Channels: req_* and rsp_* are valid/ready; a transfer happens on a clock
// edge with valid and ready both high. csr_* is a plain write port taking
// divider_num, divider_den, empty_mv, low_pct and critical_pct by index;
// write it only while no request is in flight.
// Sequence: a divider pass for the ratio scaling (a start step, 20 quotient
// bits and a done check), saturation, curve lookup, a second divider pass
// for the interpolation, flag evaluation and the hand-off to the output
// register, in that order.
// Flow: req_ready is high only while the sequencer is idle, so a new request
// is not taken before the round in flight has handed off its response.
// Reset: synchronous, active high; configuration and control registers return
// to their defaults and the first round after reset always reports.
// Stall: a finished response sits in the output register while rsp_ready is
// low; the next round may run meanwhile and then waits for that slot.
// ----------------------------------------------------------------------------
module battery_gauge_monitor_top
   import bgm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    core_valid;
   rsp_type core_data;
   logic    load;

   // Register writes; unused indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DIVIDER_NUM:  cfg_in.divider_num  = csr_wdata[NUM_W-1:0];
            CSR_DIVIDER_DEN:  cfg_in.divider_den  = csr_wdata[NUM_W-1:0];
            CSR_EMPTY_MV:     cfg_in.empty_mv     = csr_wdata[EMPTY_W-1:0];
            CSR_LOW_PCT:      cfg_in.low_pct      = csr_wdata[PCT_W-1:0];
            CSR_CRITICAL_PCT: cfg_in.critical_pct = csr_wdata[PCT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   bgm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (core_valid),
      .res_take  (load),
      .res_data  (core_data)
   );

   // Fill the output register when it is empty or being drained
   always_comb begin
      load         = core_valid && (!rsp_valid_ff || rsp_ready);
      rsp_in       = load ? core_data : rsp_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.divider_num  <= RST_DIVIDER_NUM;
         cfg_ff.divider_den  <= RST_DIVIDER_DEN;
         cfg_ff.empty_mv     <= RST_EMPTY_MV;
         cfg_ff.low_pct      <= RST_LOW_PCT;
         cfg_ff.critical_pct <= RST_CRITICAL_PCT;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
